// ===== rtl/pfau_pkg.sv =====
`default_nettype none

package pfau_pkg;

    // Field modulus and derived widths
    localparam int unsigned MODULUS = 1000000007;
    localparam int RW   = $clog2(MODULUS);
    localparam int OPW  = 30;
    localparam int EXPW = 63;
    localparam int RAWW = 64;
    localparam int CNTW = $clog2(RAWW + 1);

    localparam logic [RW-1:0]   MOD_R = MODULUS[RW-1:0];
    localparam logic [EXPW-1:0] E_INV = EXPW'(MODULUS - 2);

    // Operation codes
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_POW    = 4'd4;
    localparam logic [3:0] OP_INV    = 4'd5;
    localparam logic [3:0] OP_NEG    = 4'd6;
    localparam logic [3:0] OP_INCR   = 4'd7;
    localparam logic [3:0] OP_DECR   = 4'd8;
    localparam logic [3:0] OP_REDUCE = 4'd9;
    localparam logic [3:0] OP_CMP    = 4'd10;

endpackage

`default_nettype wire

// ===== rtl/prime_field_arithmetic_unit.sv =====
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_stall    op, left_operand, right_operand, exponent, raw_value
// out      out_valid / out_stall  residue, is_equal
//
// One transaction at a time. A bit-serial modular step unit (double, add, reduce) does all
// the work, one bit per cycle: it reduces each operand, then runs a multiply, the reduce of
// raw_value, or for pow a check, a multiply (for a set bit) and a square per exponent bit
// up to its top set bit plus one final check (inverse and divide run over MODULUS-2, divide
// adds a multiply). The result is then loaded into the output register.
// Reset clears control state; a finished result waits there while the next one is taken in.

module prime_field_arithmetic_unit
    import pfau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [3:0]             op,
    input  wire logic [OPW-1:0]         left_operand,
    input  wire logic [OPW-1:0]         right_operand,
    input  wire logic [EXPW-1:0]        exponent,
    input  wire logic signed [RAWW-1:0] raw_value,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [OPW-1:0]              residue,
    output logic                        is_equal
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED_A, ST_RED_B, ST_RED_RAW, ST_MUL_AB,
        ST_POW_CHK, ST_POW_MUL, ST_POW_SQR, ST_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      op_reg, op_next;
    logic [OPW-1:0]  b_raw_reg, b_raw_next;
    logic [RW-1:0]   a_reg, a_next;
    logic [EXPW-1:0] e_reg, e_next;
    logic            neg_reg, neg_next;
    logic [RAWW-1:0] mag_reg, mag_next;
    logic [RAWW-1:0] sr_reg, sr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]   y_reg, y_next;
    logic [RW-1:0]   acc_reg, acc_next;
    logic [RW-1:0]   base_reg, base_next;
    logic [RW-1:0]   pacc_reg, pacc_next;
    logic [RW-1:0]   res_reg, res_next;
    logic            eq_reg, eq_next;
    logic            out_valid_reg, out_valid_next;
    logic [OPW-1:0]  residue_reg, residue_next;
    logic            is_equal_reg, is_equal_next;

    // Serial step: acc = 2*acc + bit*y mod m
    logic [RW:0]   dbl, dbl_r, sum, sum_r;
    logic [RW-1:0] step_val;
    logic          last;

    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_r    = (dbl >= {1'b0, MOD_R}) ? dbl - {1'b0, MOD_R} : dbl;
        sum      = dbl_r + {1'b0, (sr_reg[RAWW-1] ? y_reg : RW'(0))};
        sum_r    = (sum >= {1'b0, MOD_R}) ? sum - {1'b0, MOD_R} : sum;
        step_val = sum_r[RW-1:0];
        last     = (cnt_reg == CNTW'(1));
    end

    // Simple ops on reduced operands
    logic [RW:0]   add_s, sub_s;
    logic [RW-1:0] simple_res;
    always_comb
    begin
        add_s = {1'b0, a_reg} + {1'b0, step_val};
        if (add_s >= {1'b0, MOD_R})
            add_s = add_s - {1'b0, MOD_R};
        sub_s = (a_reg >= step_val) ? {1'b0, a_reg} - {1'b0, step_val}
                                    : {1'b0, a_reg} + {1'b0, MOD_R} - {1'b0, step_val};
        case (op_reg)
            OP_ADD:  simple_res = add_s[RW-1:0];
            OP_SUB:  simple_res = sub_s[RW-1:0];
            OP_NEG:  simple_res = (a_reg == '0) ? '0 : MOD_R - a_reg;
            OP_INCR: simple_res = (a_reg + RW'(1) == MOD_R) ? '0 : a_reg + RW'(1);
            OP_DECR: simple_res = (a_reg == '0) ? MOD_R - RW'(1) : a_reg - RW'(1);
            default: simple_res = '0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;
    assign is_equal  = is_equal_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        b_raw_next     = b_raw_reg;
        a_next         = a_reg;
        e_next         = e_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        sr_next        = sr_reg;
        cnt_next       = cnt_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        pacc_next      = pacc_reg;
        res_next       = res_reg;
        eq_next        = eq_reg;
        out_valid_next = out_valid_reg && out_stall;
        residue_next   = residue_reg;
        is_equal_next  = is_equal_reg;

        if (state_reg != ST_IDLE && state_reg != ST_FIN && state_reg != ST_POW_CHK)
        begin
            acc_next = step_val;
            sr_next  = {sr_reg[RAWW-2:0], 1'b0};
            cnt_next = cnt_reg - CNTW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    b_raw_next = right_operand;
                    e_next     = exponent;
                    neg_next   = raw_value[RAWW-1];
                    mag_next   = raw_value[RAWW-1] ? RAWW'(0) - RAWW'(raw_value)
                                                   : RAWW'(raw_value);
                    sr_next    = {left_operand, (RAWW-OPW)'(0)};
                    cnt_next   = CNTW'(OPW);
                    y_next     = RW'(1);
                    acc_next   = '0;
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A:
            begin
                if (last)
                begin
                    a_next     = step_val;
                    sr_next    = {b_raw_reg, (RAWW-OPW)'(0)};
                    cnt_next   = CNTW'(OPW);
                    acc_next   = '0;
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B:
            begin
                if (last)
                begin
                    acc_next  = '0;
                    cnt_next  = CNTW'(RW);
                    pacc_next = RW'(1);
                    eq_next   = 1'b0;
                    case (op_reg)
                        OP_MUL:
                        begin
                            sr_next    = {a_reg, (RAWW-RW)'(0)};
                            y_next     = step_val;
                            state_next = ST_MUL_AB;
                        end
                        OP_DIV:
                        begin
                            base_next  = step_val;
                            e_next     = E_INV;
                            state_next = ST_POW_CHK;
                        end
                        OP_INV:
                        begin
                            base_next  = a_reg;
                            e_next     = E_INV;
                            state_next = ST_POW_CHK;
                        end
                        OP_POW:
                        begin
                            base_next  = a_reg;
                            state_next = ST_POW_CHK;
                        end
                        OP_REDUCE:
                        begin
                            sr_next    = mag_reg;
                            cnt_next   = CNTW'(RAWW);
                            y_next     = RW'(1);
                            state_next = ST_RED_RAW;
                        end
                        OP_CMP:
                        begin
                            res_next   = '0;
                            eq_next    = (a_reg == step_val);
                            state_next = ST_FIN;
                        end
                        default:
                        begin
                            res_next   = simple_res;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RED_RAW:
            begin
                if (last)
                begin
                    res_next   = (neg_reg && step_val != '0) ? MOD_R - step_val : step_val;
                    state_next = ST_FIN;
                end
            end
            ST_MUL_AB:
            begin
                if (last)
                begin
                    res_next   = step_val;
                    state_next = ST_FIN;
                end
            end
            ST_POW_CHK:
            begin
                acc_next = '0;
                cnt_next = CNTW'(RW);
                if (e_reg == '0)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        sr_next    = {a_reg, (RAWW-RW)'(0)};
                        y_next     = pacc_reg;
                        state_next = ST_MUL_AB;
                    end
                    else
                    begin
                        res_next   = pacc_reg;
                        state_next = ST_FIN;
                    end
                end
                else if (e_reg[0])
                begin
                    sr_next    = {pacc_reg, (RAWW-RW)'(0)};
                    y_next     = base_reg;
                    state_next = ST_POW_MUL;
                end
                else
                begin
                    sr_next    = {base_reg, (RAWW-RW)'(0)};
                    y_next     = base_reg;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL:
            begin
                if (last)
                begin
                    pacc_next  = step_val;
                    sr_next    = {base_reg, (RAWW-RW)'(0)};
                    y_next     = base_reg;
                    acc_next   = '0;
                    cnt_next   = CNTW'(RW);
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                if (last)
                begin
                    base_next  = step_val;
                    e_next     = e_reg >> 1;
                    state_next = ST_POW_CHK;
                end
            end
            ST_FIN:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    residue_next   = OPW'(res_reg);
                    is_equal_next  = eq_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        b_raw_reg    <= b_raw_next;
        a_reg        <= a_next;
        e_reg        <= e_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        sr_reg       <= sr_next;
        cnt_reg      <= cnt_next;
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        pacc_reg     <= pacc_next;
        res_reg      <= res_next;
        eq_reg       <= eq_next;
        residue_reg  <= residue_next;
        is_equal_reg <= is_equal_next;
    end

endmodule

`default_nettype wire
